@@ design/matrix4_multiply_core_macros.svh @@
// ----------------------------------------------------------------------------
// matrix4_multiply_core_macros.svh
// Assertion macros shared by the matrix multiply core.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_MULTIPLY_CORE_MACROS_SVH
`define MATRIX4_MULTIPLY_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MX4_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MX4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mx4_pkg.sv @@
// ----------------------------------------------------------------------------
// mx4_pkg
// Types and fixed constants of the matrix multiply core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mx4_pkg;

    // Binary point position of the Q16.16 format.
    localparam int FRAC_SHIFT = 16;
    // Operand digit width of the shared multiplier.
    localparam int DIGIT_W    = 32;
    // Width of the product index port.
    localparam int INDEX_W    = 4;

    typedef enum logic [0:0] {
        S_LOAD,
        S_RUN
    } t_seq_state;

    // One multiply step travelling down the pipeline.
    typedef struct packed {
        logic valid;
        logic first;   // first step of an entry: restart the sum
        logic last;    // last step of an entry
        logic di;      // digit of the left operand
        logic dj;      // digit of the right operand
    } t_step;

endpackage

@@ design/mx4_seq.sv @@
// ----------------------------------------------------------------------------
// mx4_seq
// Load counter and compute sequencer: fills the matrix stores, then walks row,
// column, term and digit; one multiply step per cycle unless the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mx4_seq
    import mx4_pkg::*;
#(
    parameter int MATRIX_DIM  = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    output logic                                      o_wr_en,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_wr_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_rd_a_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_rd_b_addr,
    output t_step                                     o_step,
    input  logic                                      i_out_pop
);

    localparam int NS    = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int IDX_W = $clog2(MATRIX_DIM * MATRIX_DIM);
    localparam int DIM_W = $clog2(MATRIX_DIM);

    t_seq_state r_state, n_state;
    logic [IDX_W-1:0] r_load, n_load;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_k, n_k;
    logic             r_di, n_di;
    logic             r_dj, n_dj;
    logic [1:0]       r_out_cnt, n_out_cnt;

    logic at_start;
    logic step_go;
    logic end_dj;
    logic end_di;
    logic end_k;
    logic end_col;
    logic end_row;
    logic entry_end;
    logic started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
            r_di      <= 1'b0;
            r_dj      <= 1'b0;
            r_out_cnt <= '0;
        end else begin
            r_load    <= n_load;
            r_row     <= n_row;
            r_col     <= n_col;
            r_k       <= n_k;
            r_di      <= n_di;
            r_dj      <= n_dj;
            r_out_cnt <= n_out_cnt;
        end
    end

    assign end_dj    = (r_dj == 1'(NS - 1));
    assign end_di    = (r_di == 1'(NS - 1));
    assign end_k     = (r_k == DIM_W'(MATRIX_DIM - 1));
    assign end_col   = (r_col == DIM_W'(MATRIX_DIM - 1));
    assign end_row   = (r_row == DIM_W'(MATRIX_DIM - 1));
    assign entry_end = end_dj && end_di && end_k;
    assign at_start  = (r_k == '0) && !r_di && !r_dj;

    assign o_rd_a_addr = IDX_W'(int'(r_row) * MATRIX_DIM + int'(r_k));
    assign o_rd_b_addr = IDX_W'(int'(r_k) * MATRIX_DIM + int'(r_col));
    assign o_wr_addr   = r_load;

    always_comb begin
        n_state   = r_state;
        n_load    = r_load;
        n_row     = r_row;
        n_col     = r_col;
        n_k       = r_k;
        n_di      = r_di;
        n_dj      = r_dj;
        o_in_ready = 1'b0;
        o_wr_en   = 1'b0;
        step_go   = 1'b0;

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_wr_en = 1'b1;
                    if (r_load == IDX_W'(MATRIX_DIM * MATRIX_DIM - 1)) begin
                        n_load  = '0;
                        n_state = S_RUN;
                    end else begin
                        n_load = r_load + 1'b1;
                    end
                end
            end
            S_RUN: begin
                // Start a new entry only when the output queue has room for it.
                step_go = !at_start || (r_out_cnt < 2'd2);
                if (step_go) begin
                    n_dj = end_dj ? 1'b0 : 1'b1;
                    if (end_dj) begin
                        n_di = end_di ? 1'b0 : 1'b1;
                    end
                    if (end_dj && end_di) begin
                        n_k = end_k ? '0 : r_k + 1'b1;
                    end
                    if (entry_end) begin
                        n_col = end_col ? '0 : r_col + 1'b1;
                        if (end_col) begin
                            n_row = end_row ? '0 : r_row + 1'b1;
                            if (end_row) begin
                                n_state = S_LOAD;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign started = step_go && at_start;

    always_comb begin
        case ({started, i_out_pop})
            2'b10:   n_out_cnt = r_out_cnt + 2'd1;
            2'b01:   n_out_cnt = r_out_cnt - 2'd1;
            default: n_out_cnt = r_out_cnt;
        endcase
    end

    assign o_step.valid = step_go;
    assign o_step.first = at_start;
    assign o_step.last  = entry_end;
    assign o_step.di    = r_di;
    assign o_step.dj    = r_dj;

endmodule

@@ design/mx4_store.sv @@
// ----------------------------------------------------------------------------
// mx4_store
// Left and right matrix memories: one write port and one registered read
// port each; the step descriptor is delayed alongside the read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mx4_store
    import mx4_pkg::*;
#(
    parameter int MATRIX_DIM  = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_wr_en,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_wr_addr,
    input  logic [VALUE_WIDTH-1:0]                    i_a_value,
    input  logic [VALUE_WIDTH-1:0]                    i_b_value,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_rd_a_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_rd_b_addr,
    input  t_step                                     i_step,
    output logic [VALUE_WIDTH-1:0]                    o_a_word,
    output logic [VALUE_WIDTH-1:0]                    o_b_word,
    output t_step                                     o_step
);

    localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;

    logic [VALUE_WIDTH-1:0] r_left_mem  [DEPTH];
    logic [VALUE_WIDTH-1:0] r_right_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_a_rd;
    logic [VALUE_WIDTH-1:0] r_b_rd;
    t_step                  r_step;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_left_mem[i_wr_addr]  <= i_a_value;
            r_right_mem[i_wr_addr] <= i_b_value;
        end
        r_a_rd <= r_left_mem[i_rd_a_addr];
        r_b_rd <= r_right_mem[i_rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= i_step;
        end
    end

    assign o_a_word = r_a_rd;
    assign o_b_word = r_b_rd;
    assign o_step   = r_step;

endmodule

@@ design/mx4_mac.sv @@
// ----------------------------------------------------------------------------
// mx4_mac
// Digit multiplier, wide accumulator, shift and saturation, and the
// two-deep output queue that drives the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix4_multiply_core_macros.svh"

module mx4_mac
    import mx4_pkg::*;
#(
    parameter int MATRIX_DIM  = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_a_word,
    input  logic [VALUE_WIDTH-1:0] i_b_word,
    input  t_step                  i_step,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_WIDTH-1:0] o_product_value,
    output logic [INDEX_W-1:0]     o_product_index,
    output logic                   o_last_entry,
    output logic                   o_pop
);

    localparam int NS    = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int EXT_W = NS * DIGIT_W;
    localparam int ACC_W = 2 * EXT_W + $clog2(MATRIX_DIM) + 2;
    localparam int PP_W  = 2 * DIGIT_W + 2;
    localparam int IDX_W = $clog2(MATRIX_DIM * MATRIX_DIM);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [VALUE_WIDTH-1:0] a_sig;
    logic signed [VALUE_WIDTH-1:0] b_sig;
    logic signed [EXT_W-1:0]       a_ext;
    logic signed [EXT_W-1:0]       b_ext;
    logic [DIGIT_W-1:0]            dig_a;
    logic [DIGIT_W-1:0]            dig_b;
    logic signed [DIGIT_W:0]       op_a;
    logic signed [DIGIT_W:0]       op_b;

    logic signed [PP_W-1:0]        r_pp;
    t_step                         r_s1;
    logic signed [ACC_W-1:0]       pp_ext;
    logic signed [ACC_W-1:0]       pp_sh;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_acc_done;
    logic signed [ACC_W-1:0]       acc_sh;
    logic [VALUE_WIDTH-1:0]        sat_value;

    logic [IDX_W-1:0]              r_cnt;
    logic                          push_last;
    logic                          pop;

    logic                          r_h_vld;
    logic [VALUE_WIDTH-1:0]        r_h_val;
    logic [IDX_W-1:0]              r_h_idx;
    logic                          r_h_last;
    logic                          r_t_vld;
    logic [VALUE_WIDTH-1:0]        r_t_val;
    logic [IDX_W-1:0]              r_t_idx;
    logic                          r_t_last;

    // Operand digits: lower digits are unsigned, the top digit carries the sign.
    assign a_sig = i_a_word;
    assign b_sig = i_b_word;
    assign a_ext = EXT_W'(a_sig);
    assign b_ext = EXT_W'(b_sig);
    assign dig_a = a_ext[i_step.di * DIGIT_W +: DIGIT_W];
    assign dig_b = b_ext[i_step.dj * DIGIT_W +: DIGIT_W];
    assign op_a  = {(i_step.di == 1'(NS - 1)) & dig_a[DIGIT_W-1], dig_a};
    assign op_b  = {(i_step.dj == 1'(NS - 1)) & dig_b[DIGIT_W-1], dig_b};

    always_ff @(posedge i_clk) begin
        r_pp <= op_a * op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1       <= i_step;
            r_acc_done <= r_s1.valid && r_s1.last;
        end
    end

    assign pp_ext = ACC_W'(r_pp);
    assign pp_sh  = pp_ext <<< (DIGIT_W * (int'(r_s1.di) + int'(r_s1.dj)));

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_acc <= r_s1.first ? pp_sh : r_acc + pp_sh;
        end
    end

    // Drop the fraction bits, rounding toward minus infinity, then clamp.
    assign acc_sh = r_acc >>> FRAC_SHIFT;

    always_comb begin
        if (acc_sh > SAT_MAX) begin
            sat_value = SAT_MAX[VALUE_WIDTH-1:0];
        end else if (acc_sh < SAT_MIN) begin
            sat_value = SAT_MIN[VALUE_WIDTH-1:0];
        end else begin
            sat_value = acc_sh[VALUE_WIDTH-1:0];
        end
    end

    assign push_last = (r_cnt == IDX_W'(MATRIX_DIM * MATRIX_DIM - 1));
    assign pop       = r_h_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_acc_done) begin
            r_cnt <= push_last ? '0 : r_cnt + 1'b1;
        end
    end

    // Two-deep output queue: head drives the ports, tail absorbs a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_t_vld <= 1'b0;
        end else if (pop) begin
            if (r_t_vld) begin
                r_h_vld  <= 1'b1;
                r_h_val  <= r_t_val;
                r_h_idx  <= r_t_idx;
                r_h_last <= r_t_last;
                r_t_vld  <= r_acc_done;
                r_t_val  <= sat_value;
                r_t_idx  <= r_cnt;
                r_t_last <= push_last;
            end else begin
                r_h_vld  <= r_acc_done;
                r_h_val  <= sat_value;
                r_h_idx  <= r_cnt;
                r_h_last <= push_last;
            end
        end else if (r_acc_done) begin
            if (!r_h_vld) begin
                r_h_vld  <= 1'b1;
                r_h_val  <= sat_value;
                r_h_idx  <= r_cnt;
                r_h_last <= push_last;
            end else begin
                r_t_vld  <= 1'b1;
                r_t_val  <= sat_value;
                r_t_idx  <= r_cnt;
                r_t_last <= push_last;
            end
        end
    end

    assign o_out_valid     = r_h_vld;
    assign o_product_value = r_h_val;
    assign o_product_index = INDEX_W'(r_h_idx);
    assign o_last_entry    = r_h_last;
    assign o_pop           = pop;

    `MX4_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, r_acc_done, !(r_h_vld && r_t_vld && !pop), "output queue overflow")
    `MX4_ASSERT_NOW(a_tail_needs_head, i_clk, i_rst_n, r_t_vld, r_h_vld, "queue tail valid with empty head")
    `MX4_ASSERT_NEXT(a_entry_spacing, i_clk, i_rst_n, r_acc_done, !r_acc_done, "entries finished on adjacent cycles")

endmodule

@@ design/matrix4_multiply_core.sv @@
// ----------------------------------------------------------------------------
// matrix4_multiply_core
// Product of two square Q16.16 matrices with saturated results.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): each request carries one element
// of A and the element of B at the same row-major position. After
// MATRIX_DIM*MATRIX_DIM requests the core emits every entry of A*B in
// row-major order on the output channel (o_out_valid / i_out_ready), with
// o_last_entry on the final one. Each entry is the exact sum of MATRIX_DIM
// products, shifted right by 16 and clamped to VALUE_WIDTH signed bits.
// The loader accepts one request per cycle. Each product entry is then built
// from MATRIX_DIM * NS * NS multiply steps, NS = ceil(VALUE_WIDTH/32), fed
// through the single read port of each matrix memory to the one 33x33 digit
// multiplier: at default sizes 16 requests and 64 steps per matrix pair. Each
// entry passes the read, product and accumulator registers into the queue.
// Loading of the next pair opens as soon as the last term has been read.
// A stalled receiver fills a two-entry output queue; the sequencer then
// waits before starting another entry. Synchronous reset empties the
// queue and restarts the loader; memory contents are left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4_multiply_core
    import mx4_pkg::*;
#(
    parameter int MATRIX_DIM  = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_a_value,
    input  logic [VALUE_WIDTH-1:0] i_b_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_WIDTH-1:0] o_product_value,
    output logic [INDEX_W-1:0]     o_product_index,
    output logic                   o_last_entry
);

    localparam int IDX_W = $clog2(MATRIX_DIM * MATRIX_DIM);

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_a_addr;
    logic [IDX_W-1:0]       rd_b_addr;
    t_step                  seq_step;
    t_step                  rd_step;
    logic [VALUE_WIDTH-1:0] a_word;
    logic [VALUE_WIDTH-1:0] b_word;
    logic                   out_pop;

    mx4_seq #(
        .MATRIX_DIM  (MATRIX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr),
        .o_step      (seq_step),
        .i_out_pop   (out_pop)
    );

    mx4_store #(
        .MATRIX_DIM  (MATRIX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_a_value   (i_a_value),
        .i_b_value   (i_b_value),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .i_step      (seq_step),
        .o_a_word    (a_word),
        .o_b_word    (b_word),
        .o_step      (rd_step)
    );

    mx4_mac #(
        .MATRIX_DIM  (MATRIX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_a_word        (a_word),
        .i_b_word        (b_word),
        .i_step          (rd_step),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_product_value (o_product_value),
        .o_product_index (o_product_index),
        .o_last_entry    (o_last_entry),
        .o_pop           (out_pop)
    );

endmodule
